[src/mcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Shared step modes, octant sequencing constants and queue status type.
// ----------------------------------------------------------------------------
package mcr_pkg;

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_e;

  localparam int unsigned OCT_BITS = 3;
  localparam logic [OCT_BITS-1:0] OCT_FIRST = 3'd0;
  localparam logic [OCT_BITS-1:0] OCT_LAST  = 3'd7;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

[src/midpoint_circle_rasterizer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer unit
// Steps a midpoint circle one iteration per input transaction and emits the
// eight symmetric points of every step.
// ----------------------------------------------------------------------------
// Every start transaction, and every advance transaction while a circle is
// running, yields eight point transactions in octant order, one per clock on
// the output channel while out_ready_i is high; the single output port limits
// the sustained step rate. The front end updates the circle state in the
// accept cycle and hands each step to a two-entry job queue, so up to two
// further steps are taken back to back while points still drain. When the
// emitter is idle, a step's first point passes through the job queue, the
// job register and the output register before it appears. Advance
// transactions with no circle running are taken and produce nothing.
module midpoint_circle_rasterizer_unit #(
  parameter int unsigned COORD_BITS = 11,
  localparam int unsigned PT_BITS   = COORD_BITS + 1,
  localparam int unsigned JOB_BITS  = 4 * COORD_BITS + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         mode_i,
  input  wire logic signed [COORD_BITS-1:0] center_x_i,
  input  wire logic signed [COORD_BITS-1:0] center_y_i,
  input  wire logic        [COORD_BITS-2:0] radius_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [PT_BITS-1:0]         point_x_o,
  output logic signed [PT_BITS-1:0]         point_y_o,
  output logic                              last_of_step_o,
  output logic                              circle_done_o
);

  logic                  push;
  logic                  pop;
  logic                  active;
  logic [JOB_BITS-1:0]   job_in;
  logic [JOB_BITS-1:0]   job_out;
  mcr_pkg::fifo_stat_t   q_stat;

  mcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .job_o      (job_in),
    .active_o   (active)
  );

  mcr_fifo #(
    .WIDTH(JOB_BITS)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .stat_o (q_stat)
  );

  mcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (!q_stat.empty),
    .job_i          (job_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  a_step_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_step_o |=> out_valid_o)
    else $error("point stream broke inside a step");

  a_done_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_step_o |=>
      circle_done_o == $past(circle_done_o))
    else $error("circle_done changed inside a step");

  a_zero_radius_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == mcr_pkg::MODE_START) &&
      (radius_i == '0) |=> !active)
    else $error("zero radius start left a circle running");

endmodule
`default_nettype wire

[src/mcr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer front end
// Accepts step transactions, updates the circle state and queues one job
// (origin, offsets, done flag) for every step that emits points.
// ----------------------------------------------------------------------------
module mcr_front #(
  parameter int unsigned COORD_BITS = 11,
  localparam int unsigned DEC_BITS  = COORD_BITS + 3,
  localparam int unsigned JOB_BITS  = 4 * COORD_BITS + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         mode_i,
  input  wire logic signed [COORD_BITS-1:0] center_x_i,
  input  wire logic signed [COORD_BITS-1:0] center_y_i,
  input  wire logic        [COORD_BITS-2:0] radius_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output logic             [JOB_BITS-1:0]   job_o,
  output logic                              active_o
);

  logic [COORD_BITS-1:0] origin_x_q, origin_x_d;
  logic [COORD_BITS-1:0] origin_y_q, origin_y_d;
  logic [COORD_BITS-1:0] off_x_q, off_x_d;
  logic [COORD_BITS-1:0] off_y_q, off_y_d;
  logic [DEC_BITS-1:0]   dec_q, dec_d;
  logic                  active_q, active_d;

  logic                  accept;
  logic                  is_start;
  logic                  done;
  logic [COORD_BITS-1:0] x_inc;
  logic [COORD_BITS-1:0] y_dec;
  logic [COORD_BITS-1:0] y_next;
  logic [DEC_BITS-1:0]   x_term;
  logic [DEC_BITS-1:0]   y_term;
  logic [DEC_BITS-1:0]   dec_adv;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = (mode_i == mcr_pkg::MODE_START);

  assign x_inc  = off_x_q + COORD_BITS'(1);
  assign y_dec  = off_y_q - COORD_BITS'(1);
  assign y_next = dec_q[DEC_BITS-1] ? off_y_q : y_dec;
  assign x_term = {2'b00, x_inc, 1'b0};
  assign y_term = {2'b00, y_dec, 1'b0};
  assign dec_adv = dec_q[DEC_BITS-1] ? (dec_q + x_term + DEC_BITS'(1))
                                     : (dec_q + x_term - y_term + DEC_BITS'(1));

  always_comb begin
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    off_x_d    = off_x_q;
    off_y_d    = off_y_q;
    dec_d      = dec_q;
    active_d   = active_q;
    done       = 1'b0;
    push_o     = 1'b0;
    if (accept && is_start) begin
      origin_x_d = center_x_i;
      origin_y_d = center_y_i;
      off_x_d    = '0;
      off_y_d    = {1'b0, radius_i};
      dec_d      = DEC_BITS'(1) - {4'b0000, radius_i};
      done       = (radius_i == '0);
      active_d   = !done;
      push_o     = 1'b1;
    end else if (accept && active_q) begin
      off_x_d  = x_inc;
      off_y_d  = y_next;
      dec_d    = dec_adv;
      done     = !(x_inc < y_next);
      active_d = !done;
      push_o   = 1'b1;
    end
  end

  assign job_o    = {done, origin_x_d, origin_y_d, off_x_d, off_y_d};
  assign active_o = active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    origin_x_q <= origin_x_d;
    origin_y_q <= origin_y_d;
    off_x_q    <= off_x_d;
    off_y_q    <= off_y_d;
    dec_q      <= dec_d;
  end

endmodule
`default_nettype wire

[src/mcr_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer job queue
// Two-entry queue between the front end and the point emitter.
// ----------------------------------------------------------------------------
module mcr_fifo #(
  parameter int unsigned WIDTH = 45
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output mcr_pkg::fifo_stat_t   stat_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

[src/mcr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer point emitter
// Takes one queued job and sends its eight octant points, one per cycle while
// the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module mcr_back #(
  parameter int unsigned COORD_BITS = 11,
  localparam int unsigned PT_BITS   = COORD_BITS + 1,
  localparam int unsigned JOB_BITS  = 4 * COORD_BITS + 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      job_valid_i,
  input  wire logic [JOB_BITS-1:0]       job_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [PT_BITS-1:0]      point_x_o,
  output logic signed [PT_BITS-1:0]      point_y_o,
  output logic                           last_of_step_o,
  output logic                           circle_done_o
);

  logic [JOB_BITS-1:0]                   job_q;
  logic [mcr_pkg::OCT_BITS-1:0]          oct_q, oct_d;
  logic                                  busy_q, busy_d;
  logic                                  out_valid_q, out_valid_d;
  logic [PT_BITS-1:0]                    px_q, py_q;
  logic                                  last_q, done_q;

  logic                                  load;
  logic                                  emit;
  logic                                  oct_last;
  logic                                  j_done;
  logic [COORD_BITS-1:0]                 j_ox, j_oy, j_x, j_y;
  logic [COORD_BITS-1:0]                 a, b;
  logic [PT_BITS-1:0]                    ox_e, oy_e, a_e, b_e;
  logic [PT_BITS-1:0]                    px, py;

  assign {j_done, j_ox, j_oy, j_x, j_y} = job_q;

  assign load     = !out_valid_q || out_ready_i;
  assign emit     = busy_q && load;
  assign oct_last = (oct_q == mcr_pkg::OCT_LAST);
  assign pop_o    = job_valid_i && (!busy_q || (emit && oct_last));

  assign a    = oct_q[2] ? j_y : j_x;
  assign b    = oct_q[2] ? j_x : j_y;
  assign ox_e = {j_ox[COORD_BITS-1], j_ox};
  assign oy_e = {j_oy[COORD_BITS-1], j_oy};
  assign a_e  = {1'b0, a};
  assign b_e  = {1'b0, b};
  assign px   = oct_q[0] ? (ox_e - a_e) : (ox_e + a_e);
  assign py   = oct_q[1] ? (oy_e - b_e) : (oy_e + b_e);

  always_comb begin
    oct_d  = oct_q;
    busy_d = busy_q;
    if (emit) begin
      oct_d = oct_q + mcr_pkg::OCT_BITS'(1);
      if (oct_last) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      oct_d  = mcr_pkg::OCT_FIRST;
      busy_d = 1'b1;
    end
    out_valid_d = load ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q       <= mcr_pkg::OCT_FIRST;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      oct_q       <= oct_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      px_q   <= px;
      py_q   <= py;
      last_q <= oct_last;
      done_q <= j_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer unit testbench
// Feeds start and advance transactions through a valid/ready driver with
// random idling on both channels. Expected octant points come from a
// behavioral circle stepper and are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CB = 11;
  localparam int RB = CB - 1;
  localparam int PB = CB + 1;
  localparam int DB = CB + 3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [CB-1:0] ox;
    logic signed [CB-1:0] oy;
    logic [CB-1:0]        ux;
    logic [CB-1:0]        uy;
    logic signed [CB+2:0] dec;
    logic                 active;
  } circle_t;

  typedef struct packed {
    logic signed [PB-1:0] px;
    logic signed [PB-1:0] py;
    logic                 last;
    logic                 done;
  } point_t;

  typedef struct {
    mcr_pkg::mode_e       mode;
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [CB-2:0]        r;
    int                   gap;
    bit                   drain;
  } step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i = mcr_pkg::MODE_START;
  logic signed [CB-1:0] center_x_i = '0;
  logic signed [CB-1:0] center_y_i = '0;
  logic [CB-2:0]        radius_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [PB-1:0] point_x_o;
  logic signed [PB-1:0] point_y_o;
  logic                 last_of_step_o;
  logic                 circle_done_o;

  step_t   step_queue[$];
  point_t  pending_points[$];
  circle_t gen_circle = '0;
  circle_t live_circle = '0;
  step_t   cur_step;
  point_t  want;
  int      gen_emits = 0;
  int      tx_gap = 0;
  int      rx_stall = 0;
  bit      rx_calm = 1'b0;
  bit      in_acc = 1'b0;
  bit      out_acc = 1'b0;
  int      cycles = 0;
  int      errors = 0;
  int      n_starts = 0;
  int      n_advances = 0;
  int      n_points = 0;
  int      n_circles = 0;

  midpoint_circle_rasterizer_unit #(.COORD_BITS(CB)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .last_of_step_o(last_of_step_o),
    .circle_done_o (circle_done_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Returns 1 when the transaction yields a set of eight points.
  function automatic bit circle_step(inout circle_t s, input mcr_pkg::mode_e m,
                                     input logic signed [CB-1:0] cx,
                                     input logic signed [CB-1:0] cy,
                                     input logic [CB-2:0] r);
    int x;
    int y;
    int d;
    if (m == mcr_pkg::MODE_START) begin
      s.ox = cx;
      s.oy = cy;
      s.ux = '0;
      s.uy = {1'b0, r};
      s.dec = DB'(1 - int'(r));
      s.active = (r != 0);
      return 1'b1;
    end
    if (!s.active) return 1'b0;
    x = int'(s.ux) + 1;
    y = int'(s.uy);
    d = int'(s.dec);
    if (d < 0) begin
      d = d + 2 * x + 1;
    end else begin
      y = y - 1;
      d = d + 2 * x - 2 * y + 1;
    end
    s.ux = CB'(x);
    s.uy = CB'(y);
    s.dec = DB'(d);
    s.active = (x < y);
    return 1'b1;
  endfunction

  function automatic point_t octant_point(circle_t s, int k);
    int a;
    int b;
    int px;
    int py;
    point_t p;
    a = (k < 4) ? int'(s.ux) : int'(s.uy);
    b = (k < 4) ? int'(s.uy) : int'(s.ux);
    px = int'(s.ox) + (k[0] ? -a : a);
    py = int'(s.oy) + (k[1] ? -b : b);
    p.px = PB'(px);
    p.py = PB'(py);
    p.last = (k == int'(mcr_pkg::OCT_LAST));
    p.done = !s.active;
    return p;
  endfunction

  function automatic int draw_wait(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  task automatic add_step(mcr_pkg::mode_e m, logic signed [CB-1:0] cx,
                          logic signed [CB-1:0] cy, logic [CB-2:0] r, int gap,
                          bit drain);
    step_t s;
    s.mode = m;
    s.cx = cx;
    s.cy = cy;
    s.r = r;
    s.gap = gap;
    s.drain = drain;
    step_queue.push_back(s);
    if (circle_step(gen_circle, m, cx, cy, r)) gen_emits++;
  endtask

  task automatic add_advance(bit calm);
    add_step(mcr_pkg::MODE_ADVANCE, CB'($urandom), CB'($urandom), RB'($urandom),
             draw_wait(calm), 1'b0);
  endtask

  // Driver: hold the payload until the transaction is taken, then idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (step_queue.size() != 0 &&
                   !(step_queue[0].drain && pending_points.size() != 0)) begin
        cur_step = step_queue.pop_front();
        mode_i <= cur_step.mode;
        center_x_i <= cur_step.cx;
        center_y_i <= cur_step.cy;
        radius_i <= cur_step.r;
        tx_gap <= cur_step.gap;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_acc) begin
      rx_stall = draw_wait(rx_calm);
      if ($urandom_range(0, 40) == 0) rx_calm = !rx_calm;
    end
    if (rst_ni && rx_stall == 0) begin
      out_ready_i <= 1'b1;
    end else begin
      if (rx_stall > 0) rx_stall = rx_stall - 1;
      out_ready_i <= 1'b0;
    end
  end

  // Monitor: check point transactions, then predict from accepted steps.
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d points outstanding", $time, pending_points.size());
      $display("tb_top: errors");
      $finish;
    end else if (rst_ni) begin
      in_acc <= in_valid_i && in_ready_o;
      out_acc <= out_valid_o && out_ready_i;
      if (out_valid_o && out_ready_i) begin
        n_points++;
        if (pending_points.size() == 0) begin
          errors++;
          $display("%0t unexpected point (%0d, %0d) last %0b done %0b", $time,
                   point_x_o, point_y_o, last_of_step_o, circle_done_o);
        end else begin
          want = pending_points.pop_front();
          if (point_x_o !== want.px) begin
            errors++;
            $display("%0t point_x expected %0d got %0d", $time, want.px, point_x_o);
          end
          if (point_y_o !== want.py) begin
            errors++;
            $display("%0t point_y expected %0d got %0d", $time, want.py, point_y_o);
          end
          if (last_of_step_o !== want.last) begin
            errors++;
            $display("%0t last_of_step expected %0b got %0b", $time, want.last,
                     last_of_step_o);
          end
          if (circle_done_o !== want.done) begin
            errors++;
            $display("%0t circle_done expected %0b got %0b", $time, want.done,
                     circle_done_o);
          end
          if (want.last && want.done) n_circles++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (mode_i == mcr_pkg::MODE_START) n_starts++;
        else n_advances++;
        if (circle_step(live_circle, mcr_pkg::mode_e'(mode_i), center_x_i, center_y_i,
                        radius_i)) begin
          for (int k = 0; k <= int'(mcr_pkg::OCT_LAST); k++) begin
            pending_points.push_back(octant_point(live_circle, k));
          end
        end
      end
    end
  end

  initial begin
    bit calm;
    int sel;
    int cap;
    int n;
    int seq_n;
    logic [CB-2:0] r;

    // advance while idle, zero radius at the origin and the corners
    add_step(mcr_pkg::MODE_ADVANCE, 11'sd0, 11'sd0, 10'd0, 0, 1'b0);
    add_step(mcr_pkg::MODE_START, 11'sd0, 11'sd0, 10'd0, 0, 1'b0);
    add_step(mcr_pkg::MODE_ADVANCE, 11'sd1023, -11'sd1024, 10'd1023, 0, 1'b0);
    add_step(mcr_pkg::MODE_START, 11'sd1023, 11'sd1023, 10'd0, 0, 1'b0);
    add_step(mcr_pkg::MODE_START, -11'sd1024, -11'sd1024, 10'd0, 0, 1'b0);
    // largest radius at extreme centers, restarted while running
    add_step(mcr_pkg::MODE_START, 11'sd1023, -11'sd1024, 10'd1023, 0, 1'b0);
    repeat (3) add_advance(1'b1);
    add_step(mcr_pkg::MODE_START, -11'sd1024, 11'sd1023, 10'd1023, 0, 1'b0);
    repeat (2) add_advance(1'b1);
    add_step(mcr_pkg::MODE_START, -11'sd1024, -11'sd1024, 10'd1023, 0, 1'b0);
    add_advance(1'b1);
    // tiny circles run to completion, the first followed by one stray advance
    add_step(mcr_pkg::MODE_START, 11'sd5, -11'sd7, 10'd1, 0, 1'b0);
    add_advance(1'b1);
    add_advance(1'b1);
    add_step(mcr_pkg::MODE_START, 11'sd0, 11'sd0, 10'd2, 0, 1'b0);
    while (gen_circle.active) add_advance(1'b1);
    add_step(mcr_pkg::MODE_START, -11'sd3, 11'sd9, 10'd5, 0, 1'b1);
    while (gen_circle.active) add_advance(1'b0);

    seq_n = 0;
    while (gen_emits < 400) begin
      calm = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 9);
      if (sel < 6) r = RB'($urandom_range(0, 20));
      else if (sel < 8) r = RB'($urandom_range(21, 120));
      else r = RB'($urandom_range(0, 1023));
      add_step(mcr_pkg::MODE_START, CB'($urandom), CB'($urandom), r, draw_wait(calm),
               (seq_n % 25) == 24);
      cap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 40;
      n = 0;
      while (gen_circle.active && n < cap) begin
        add_advance(calm);
        n++;
      end
      if ($urandom_range(0, 3) == 0) add_advance(calm);
      seq_n++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (step_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d starts and %0d advances, %0d points checked, %0d circles closed",
             n_starts, n_advances, n_points, n_circles);
    $display("%0d mismatches in %0d cycles", errors, cycles);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[files.f]
src/mcr_pkg.sv
src/mcr_front.sv
src/mcr_fifo.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer_unit.sv
verif/tb_top.sv
